// ===== rtl/ps2mct_pkg.sv =====
// Shared types and constants for the PS/2 mouse cursor tracker.
`timescale 1ns / 1ps

package ps2mct_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned MOVE_W = 9;
  localparam int unsigned SUM_W  = 11;
  localparam int unsigned IDX_W  = 2;

  // Status byte bit positions
  localparam int unsigned LEFT_BIT  = 0;
  localparam int unsigned RIGHT_BIT = 1;
  localparam int unsigned SYNC_BIT  = 3;
  localparam int unsigned X_SIGN    = 4;
  localparam int unsigned Y_SIGN    = 5;
  localparam int unsigned X_OVF     = 6;
  localparam int unsigned Y_OVF     = 7;

  // Register reset values
  localparam logic [POS_W-1:0] X_LIMIT_RST = 9'd314;
  localparam logic [POS_W-1:0] Y_LIMIT_RST = 9'd234;
  localparam logic [POS_W-1:0] X_HOME_RST  = 9'd160;
  localparam logic [POS_W-1:0] Y_HOME_RST  = 9'd120;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_X_LIMIT = 2'd0;
  localparam logic [IDX_W-1:0] REG_Y_LIMIT = 2'd1;
  localparam logic [IDX_W-1:0] REG_X_HOME  = 2'd2;
  localparam logic [IDX_W-1:0] REG_Y_HOME  = 2'd3;

  // Packet framing phase: which byte of the packet comes next
  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_XMOVE  = 2'd1,
    PH_YMOVE  = 2'd2
  } pkt_phase_t;

endpackage

// ===== rtl/ps2_mouse_cursor_tracker.sv =====
// PS/2 mouse packet decoder and clamped cursor tracker (top level).
`timescale 1ns / 1ps
// Data path: a transferred byte lands in the input register; a packet's result is loaded
//   from there into the output register, which drives out_valid, once the third byte is
//   in the input register and the output register is free or being taken.
// Throughput: one byte per cycle; the input register stalls only when a finished packet
//   meets an output register that is still full and not being taken.
// Reset (rst_n low, synchronous): framing to the status byte, pipeline emptied,
//   limits to 314/234 and cursor to the home position 160/120.

module ps2_mouse_cursor_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ps2mct_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ps2mct_pkg::POS_W-1:0]     out_cursor_x,
  output logic [ps2mct_pkg::POS_W-1:0]     out_cursor_y,
  output logic signed [ps2mct_pkg::MOVE_W-1:0] out_move_x,
  output logic signed [ps2mct_pkg::MOVE_W-1:0] out_move_y,
  output logic                             out_left_button,
  output logic                             out_right_button,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ps2mct_pkg::IDX_W-1:0]     cfg_index,
  input  logic [ps2mct_pkg::POS_W-1:0]     cfg_data
);

  import ps2mct_pkg::*;

  // Configuration registers
  logic [POS_W-1:0] x_limit_r, y_limit_r;

  // Input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // Packet state
  pkt_phase_t        phase_r, phase_nxt;
  logic [BYTE_W-1:0] status_r, status_nxt;
  logic [BYTE_W-1:0] xbyte_r, xbyte_nxt;
  logic [POS_W-1:0]  pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]  pos_y_r, pos_y_nxt;

  // Output register
  logic                     out_valid_r;
  logic [POS_W-1:0]         out_cursor_x_r, out_cursor_y_r;
  logic signed [MOVE_W-1:0] out_move_x_r, out_move_y_r;
  logic                     out_left_r, out_right_r;

  // Handshake control
  logic out_free;
  logic s1_result;
  logic s1_go;
  logic in_xfer;
  logic cfg_xfer;

  // Datapath
  logic signed [MOVE_W-1:0] move_x, move_y;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic [POS_W-1:0]         clamp_x, clamp_y;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;

  // Pipeline control: a non-final byte never waits on the output side
  assign out_free  = !out_valid_r || out_ready;
  assign s1_result = (phase_r == PH_YMOVE);
  assign s1_go     = s1_valid_r && (!s1_result || out_free);
  assign in_ready  = !s1_valid_r || s1_go;
  assign in_xfer   = in_valid && in_ready;

  // Hold the received byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Framing next state
  always_comb begin
    phase_nxt = phase_r;
    if (s1_go) begin
      unique case (phase_r)
        PH_XMOVE: phase_nxt = PH_YMOVE;
        PH_YMOVE: phase_nxt = PH_STATUS;
        default:  phase_nxt = s1_byte_r[SYNC_BIT] ? PH_XMOVE : PH_STATUS;
      endcase
    end
  end

  // Sign-extend and overflow-zero the movements
  always_comb begin
    move_x = status_r[X_OVF] ? '0 : $signed({status_r[X_SIGN], xbyte_r});
    move_y = status_r[Y_OVF] ? '0 : $signed({status_r[Y_SIGN], s1_byte_r});
    sum_x  = $signed({2'b00, pos_x_r}) + $signed({{(SUM_W-MOVE_W){move_x[MOVE_W-1]}}, move_x});
    sum_y  = $signed({2'b00, pos_y_r}) - $signed({{(SUM_W-MOVE_W){move_y[MOVE_W-1]}}, move_y});
  end

  // Clamp each axis to 0..limit
  always_comb begin
    if (sum_x[SUM_W-1]) begin
      clamp_x = '0;
    end else if (sum_x > $signed({2'b00, x_limit_r})) begin
      clamp_x = x_limit_r;
    end else begin
      clamp_x = sum_x[POS_W-1:0];
    end
    if (sum_y[SUM_W-1]) begin
      clamp_y = '0;
    end else if (sum_y > $signed({2'b00, y_limit_r})) begin
      clamp_y = y_limit_r;
    end else begin
      clamp_y = sum_y[POS_W-1:0];
    end
  end

  // Capture packet bytes and update the cursor; a home write moves the cursor
  always_comb begin
    status_nxt = status_r;
    xbyte_nxt  = xbyte_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    if (s1_go) begin
      case (phase_r)
        PH_XMOVE: xbyte_nxt = s1_byte_r;
        PH_YMOVE: begin
          pos_x_nxt = clamp_x;
          pos_y_nxt = clamp_y;
        end
        default: begin
          if (s1_byte_r[SYNC_BIT]) begin
            status_nxt = s1_byte_r;
          end
        end
      endcase
    end
    if (cfg_xfer && cfg_index == REG_X_HOME) begin
      pos_x_nxt = cfg_data;
    end
    if (cfg_xfer && cfg_index == REG_Y_HOME) begin
      pos_y_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_STATUS;
      status_r <= '0;
      xbyte_r  <= '0;
      pos_x_r  <= X_HOME_RST;
      pos_y_r  <= Y_HOME_RST;
    end else begin
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
      xbyte_r  <= xbyte_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
    end
  end

  // Configuration writes; a home write only moves the cursor, in the packet state above
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RST;
      y_limit_r <= Y_LIMIT_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        REG_X_LIMIT: x_limit_r <= cfg_data;
        REG_Y_LIMIT: y_limit_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Output register: load a finished packet, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_result) begin
      out_cursor_x_r <= clamp_x;
      out_cursor_y_r <= clamp_y;
      out_move_x_r   <= move_x;
      out_move_y_r   <= move_y;
      out_left_r     <= status_r[LEFT_BIT];
      out_right_r    <= status_r[RIGHT_BIT];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cursor_x     = out_cursor_x_r;
  assign out_cursor_y     = out_cursor_y_r;
  assign out_move_x       = out_move_x_r;
  assign out_move_y       = out_move_y_r;
  assign out_left_button  = out_left_r;
  assign out_right_button = out_right_r;

`ifndef SYNTHESIS
  // A finished packet always reaches the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_result |=> out_valid_r)
    else $error("finished packet not loaded into output register");

  // Status and X bytes never stall the input
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_result |-> in_ready)
    else $error("non-final byte stalled the input");

  // A finished packet waits while the output register is held
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_result && out_valid_r && !out_ready |-> !in_ready && !s1_go)
    else $error("packet overwrote a pending result");

  // Framing advances only on a consumed byte
  assert property (@(posedge clk) disable iff (!rst_n)
    !s1_go && !cfg_xfer |=> phase_r == $past(phase_r) && pos_x_r == $past(pos_x_r))
    else $error("packet state changed without a byte");
`endif

endmodule

// ===== verif/ps2_mouse_cursor_tracker_tb.sv =====
// Self-checking testbench for the PS/2 mouse cursor tracker.
`timescale 1ns / 1ps

module ps2_mouse_cursor_tracker_tb;
  import ps2mct_pkg::*;

  localparam int SIGN_SPAN     = 256;
  localparam int IDLE_PCT      = 38;
  localparam int SETTLE_CYCLES = 8;
  localparam int RAND_BYTES    = 1500;
  localparam int RAND_PHASES   = 5;
  localparam int MAX_REPORTS   = 10;
  localparam time TIMEOUT_NS   = 20_000_000;

  typedef struct packed {
    logic [POS_W-1:0]         cx;
    logic [POS_W-1:0]         cy;
    logic signed [MOVE_W-1:0] mx;
    logic signed [MOVE_W-1:0] my;
    logic                     lb;
    logic                     rb;
  } cursor_report_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [BYTE_W-1:0] in_rx_byte;
  logic out_valid;
  logic out_ready;
  logic [POS_W-1:0] out_cursor_x;
  logic [POS_W-1:0] out_cursor_y;
  logic signed [MOVE_W-1:0] out_move_x;
  logic signed [MOVE_W-1:0] out_move_y;
  logic out_left_button;
  logic out_right_button;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [POS_W-1:0] cfg_data;

  ps2_mouse_cursor_tracker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cursor_x     (out_cursor_x),
    .out_cursor_y     (out_cursor_y),
    .out_move_x       (out_move_x),
    .out_move_y       (out_move_y),
    .out_left_button  (out_left_button),
    .out_right_button (out_right_button),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Mirror of the tracker state
  pkt_phase_t       frame_phase;
  logic [BYTE_W-1:0] held_status;
  logic [BYTE_W-1:0] held_x;
  logic [POS_W-1:0] cur_x, cur_y;
  logic [POS_W-1:0] lim_x, lim_y;

  cursor_report_t pending_reports[$];

  int err_cnt;
  int bytes_sent;
  int bytes_dropped;
  int framed_bytes;
  int reports_checked;
  int reg_writes;
  bit calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit idle_roll();
    if (calm) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input int v, input logic [POS_W-1:0] hi);
    if (v < 0) return '0;
    if (v > int'(hi)) return hi;
    return POS_W'(v);
  endfunction

  function automatic int decode_move(input logic [BYTE_W-1:0] raw, input bit sign_set,
                                     input bit ovf_set);
    int m;
    m = int'(raw);
    if (sign_set) m -= SIGN_SPAN;
    if (ovf_set) m = 0;
    return m;
  endfunction

  // Advance the packet framing by one byte; queue a report on the third byte
  function automatic void track_byte(input logic [BYTE_W-1:0] b);
    cursor_report_t r;
    int dx, dy;
    case (frame_phase)
      PH_XMOVE: begin
        held_x = b;
        frame_phase = PH_YMOVE;
        framed_bytes++;
      end
      PH_YMOVE: begin
        frame_phase = PH_STATUS;
        framed_bytes++;
        dx = decode_move(held_x, held_status[X_SIGN], held_status[X_OVF]);
        dy = decode_move(b, held_status[Y_SIGN], held_status[Y_OVF]);
        cur_x = clamp_pos(int'(cur_x) + dx, lim_x);
        cur_y = clamp_pos(int'(cur_y) - dy, lim_y);
        r.cx = cur_x;
        r.cy = cur_y;
        r.mx = MOVE_W'(dx);
        r.my = MOVE_W'(dy);
        r.lb = held_status[LEFT_BIT];
        r.rb = held_status[RIGHT_BIT];
        pending_reports.push_back(r);
      end
      default: begin
        if (b[SYNC_BIT]) begin
          held_status = b;
          frame_phase = PH_XMOVE;
          framed_bytes++;
        end else begin
          frame_phase = PH_STATUS;
          bytes_dropped++;
        end
      end
    endcase
  endfunction

  function automatic void model_reset();
    lim_x = X_LIMIT_RST;
    lim_y = Y_LIMIT_RST;
    cur_x = X_HOME_RST;
    cur_y = Y_HOME_RST;
    frame_phase = PH_STATUS;
    held_status = '0;
    held_x = '0;
  endfunction

  // Hold the byte on the bus until the transfer, then update the mirror
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] x,
                             input logic [BYTE_W-1:0] y);
    send_byte(s);
    send_byte(x);
    send_byte(y);
  endtask

  // Drop valid, wait for every report, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_X_LIMIT: lim_x = val;
      REG_Y_LIMIT: lim_y = val;
      REG_X_HOME:  cur_x = val;
      REG_Y_HOME:  cur_y = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [POS_W-1:0] xl, input logic [POS_W-1:0] yl,
                           input logic [POS_W-1:0] xh, input logic [POS_W-1:0] yh);
    write_reg(REG_X_LIMIT, xl);
    write_reg(REG_Y_LIMIT, yl);
    write_reg(REG_X_HOME, xh);
    write_reg(REG_Y_HOME, yh);
  endtask

  // Stall the result side at random, except in calm stretches
  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each result transfer with the oldest expected report
  always @(posedge clk) begin
    cursor_report_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.cx = out_cursor_x;
      got.cy = out_cursor_y;
      got.mx = out_move_x;
      got.my = out_move_y;
      got.lb = out_left_button;
      got.rb = out_right_button;
      if (pending_reports.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected report: x=%0d y=%0d dx=%0d dy=%0d l=%0b r=%0b",
                   got.cx, got.cy, got.mx, got.my, got.lb, got.rb);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("mismatch: exp x=%0d y=%0d dx=%0d dy=%0d l=%0b r=%0b",
                     want.cx, want.cy, want.mx, want.my, want.lb, want.rb);
            $display("          got x=%0d y=%0d dx=%0d dy=%0d l=%0b r=%0b",
                     got.cx, got.cy, got.mx, got.my, got.lb, got.rb);
          end
        end
      end
    end
  end

  // Bytes without the sync bit are dropped, then a still packet reports home
  task automatic test_sync_drop();
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h08, 8'h00, 8'h00);
    drain();
  endtask

  // Sign, overflow and button bits, with the byte extremes
  task automatic test_move_decode();
    send_packet(8'h0B, 8'h7F, 8'h80);
    send_packet(8'h38, 8'h01, 8'hFF);
    send_packet(8'hF9, 8'hFF, 8'h00);
    send_packet(8'h1A, 8'hFF, 8'h00);
    drain();
  endtask

  // Limits and homes at their extremes, cursor past its limit, home moved mid-packet
  task automatic test_limits_homes();
    write_all(9'd0, 9'd0, 9'd511, 9'd511);
    send_packet(8'h08, 8'h00, 8'h00);
    drain();
    write_all(9'd511, 9'd511, 9'd0, 9'd0);
    send_packet(8'h08, 8'h7F, 8'h80);
    send_packet(8'h08, 8'hFF, 8'h00);
    send_packet(8'h28, 8'hFF, 8'h00);
    drain();
    send_byte(8'h09);
    send_byte(8'h05);
    drain();
    write_reg(REG_X_HOME, 9'd300);
    send_byte(8'h28);
    drain();
  endtask

  // Mostly well-formed packets with random content; some noise and cut-off packets
  task automatic test_random_traffic();
    int target, dx, dy;
    logic [BYTE_W-1:0] st;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: write_all(9'd511, 9'd511, 9'd0, 9'd0);
        1: write_all(9'($urandom_range(0, 100)), 9'($urandom_range(0, 100)),
                     9'd511, 9'd511);
        default: write_all(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                           9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
      endcase
      calm = (p == 2);
      target = framed_bytes + RAND_BYTES / RAND_PHASES;
      while (framed_bytes < target) begin
        case ($urandom_range(0, 19))
          0, 1: send_byte(8'($urandom));
          2: begin
            send_byte(8'($urandom) | 8'h08);
            send_byte(8'($urandom));
          end
          default: begin
            if ($urandom_range(0, 9) < 7) begin
              dx = int'($urandom_range(0, 80)) - 40;
              dy = int'($urandom_range(0, 80)) - 40;
            end else begin
              dx = int'($urandom_range(0, 511)) - SIGN_SPAN;
              dy = int'($urandom_range(0, 511)) - SIGN_SPAN;
            end
            st = 8'($urandom);
            st[SYNC_BIT] = 1'b1;
            st[X_SIGN] = dx < 0;
            st[Y_SIGN] = dy < 0;
            st[X_OVF] = $urandom_range(0, 9) == 0;
            st[Y_OVF] = $urandom_range(0, 9) == 0;
            send_packet(st, 8'(dx), 8'(dy));
          end
        endcase
      end
      drain();
      calm = 1'b0;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    err_cnt = 0;
    bytes_sent = 0;
    bytes_dropped = 0;
    framed_bytes = 0;
    reports_checked = 0;
    reg_writes = 0;
    model_reset();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_sync_drop();
    test_move_decode();
    test_limits_homes();
    test_random_traffic();

    drain();
    if (pending_reports.size() != 0) begin
      err_cnt++;
      $display("%0d expected reports never arrived", pending_reports.size());
    end
    $display("covered %0d bytes (%0d dropped for missing sync), %0d reports checked",
             bytes_sent, bytes_dropped, reports_checked);
    $display("covered %0d register writes, %0d failures", reg_writes, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d reports outstanding", pending_reports.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
